>>> hw/rtl/tlpt_pkg.sv
package tlpt_pkg;

    localparam int DEF_NUM_PAGES = 64;
    localparam int TABLE_ENTRIES = 1024;
    localparam int OFF_W         = 10;
    localparam int PAGE_SHIFT    = 12;
    localparam logic [2:0] ENTRY_FLAGS = 3'd7;

    // actions
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_GROW   = 2'd1;
    localparam logic [1:0] ACT_SHRINK = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // counter ops
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_CLR  = 2'd1;
    localparam logic [1:0] CNT_INC  = 2'd2;

    // address source
    localparam logic [1:0] ADDR_PAGE  = 2'd0;
    localparam logic [1:0] ADDR_CNT   = 2'd1;
    localparam logic [1:0] ADDR_WADDR = 2'd2;

    // page select
    localparam logic [1:0] PSEL_ROOT = 2'd0;
    localparam logic [1:0] PSEL_TBL  = 2'd1;
    localparam logic [1:0] PSEL_PG   = 2'd2;

    // offset select
    localparam logic [2:0] OFF_CNT = 3'd0;
    localparam logic [2:0] OFF_F   = 3'd1;
    localparam logic [2:0] OFF_FM1 = 3'd2;
    localparam logic [2:0] OFF_S   = 3'd3;
    localparam logic [2:0] OFF_SM1 = 3'd4;

    // value update
    localparam logic [1:0] VAL_HOLD   = 2'd0;
    localparam logic [1:0] VAL_RDATA  = 2'd1;
    localparam logic [1:0] VAL_PGADDR = 2'd2;
    localparam logic [1:0] VAL_DPAGE  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [17:0] table_root;
        logic [15:0] word_address;
    } req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        error;
        logic [6:0]  free_count;
    } rsp_t;

    typedef struct packed {
        logic       ld_in;
        logic [1:0] cnt_op;
        logic [1:0] pg_op;
        logic       mem_we;
        logic [1:0] addr_sel;
        logic [1:0] psel;
        logic [2:0] off_sel;
        logic       wd_entry;
        logic       save_f;
        logic       save_s;
        logic       save_last;
        logic       save_tpage;
        logic       tpage_from_pg;
        logic       take;
        logic       rel_data;
        logic       rel_tpage;
        logic [1:0] val_op;
        logic       set_err;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       clr_last;
        logic       cnt_full;
        logic       cnt_off_last;
        logic       rdata_present;
        logic       root_ok;
        logic       tpage_ok;
        logic       free_zero;
        logic       free_lt2;
        logic       pg_free;
        logic       f_zero;
        logic       f_full;
        logic       s_zero;
        logic       s_one;
        logic       s_full;
    } sts_t;

endpackage

>>> hw/rtl/tlpt_datapath.sv
module tlpt_datapath #(
    parameter int NUM_PAGES = tlpt_pkg::DEF_NUM_PAGES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tlpt_pkg::req_t req,
    input  tlpt_pkg::cmd_t cmd,
    output tlpt_pkg::sts_t sts,
    output tlpt_pkg::rsp_t rsp
);
    import tlpt_pkg::*;

    localparam int PW        = $clog2(NUM_PAGES);
    localparam int AW        = PW + OFF_W;
    localparam int MEM_WORDS = NUM_PAGES * TABLE_ENTRIES;
    localparam int FW        = $clog2(NUM_PAGES + 1);
    localparam int TW        = OFF_W + 1;

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rdata_reg;

    logic [1:0]           action_reg;
    logic [5:0]           root_reg;
    logic [15:0]          waddr_reg;
    logic [AW-1:0]        cnt_reg;
    logic [PW-1:0]        pg_reg;
    logic [PW-1:0]        tpage_reg;
    logic [TW-1:0]        f_reg;
    logic [TW-1:0]        s_reg;
    logic [31:0]          last_reg;
    logic [31:0]          value_reg;
    logic                 err_reg;
    logic [NUM_PAGES-1:0] free_map_reg;
    logic [FW-1:0]        free_reg;

    logic [PW-1:0]    page_sel;
    logic [OFF_W-1:0] off_sel;
    logic [AW-1:0]    addr;
    logic [31:0]      wdata;
    logic [TW-1:0]    f_m1;
    logic [TW-1:0]    s_m1;
    logic [19:0]      d_page;
    logic             d_ok;
    logic             waddr_ok;

    assign f_m1     = f_reg - TW'(1);
    assign s_m1     = s_reg - TW'(1);
    assign d_page   = last_reg[31:PAGE_SHIFT];
    assign d_ok     = 32'(d_page) < 32'(NUM_PAGES);
    assign waddr_ok = 32'(waddr_reg) < 32'(MEM_WORDS);

    always_comb
    begin
        unique case (cmd.psel)
            PSEL_ROOT: page_sel = PW'(root_reg);
            PSEL_TBL:  page_sel = tpage_reg;
            default:   page_sel = pg_reg;
        endcase
        unique case (cmd.off_sel)
            OFF_F:   off_sel = f_reg[OFF_W-1:0];
            OFF_FM1: off_sel = f_m1[OFF_W-1:0];
            OFF_S:   off_sel = s_reg[OFF_W-1:0];
            OFF_SM1: off_sel = s_m1[OFF_W-1:0];
            default: off_sel = cnt_reg[OFF_W-1:0];
        endcase
        unique case (cmd.addr_sel)
            ADDR_CNT:   addr = cnt_reg;
            ADDR_WADDR: addr = AW'(waddr_reg);
            default:    addr = {page_sel, off_sel};
        endcase
        wdata = cmd.wd_entry ? ((32'(pg_reg) << PAGE_SHIFT) | 32'(ENTRY_FLAGS)) : 32'd0;
    end

    // single port page memory, read first
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            pg_reg       <= '0;
            err_reg      <= 1'b0;
            free_map_reg <= '1;
            free_reg     <= FW'(NUM_PAGES);
        end
        else
        begin
            unique case (cmd.cnt_op)
                CNT_CLR: cnt_reg <= '0;
                CNT_INC: cnt_reg <= cnt_reg + AW'(1);
                default: cnt_reg <= cnt_reg;
            endcase
            unique case (cmd.pg_op)
                CNT_CLR: pg_reg <= '0;
                CNT_INC: pg_reg <= pg_reg + PW'(1);
                default: pg_reg <= pg_reg;
            endcase
            if (cmd.ld_in)
            begin
                err_reg <= 1'b0;
            end
            if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
            priority if (cmd.take)
            begin
                free_map_reg[pg_reg] <= 1'b0;
                free_reg             <= free_reg - FW'(1);
            end
            else if (cmd.rel_data && d_ok && !free_map_reg[d_page[PW-1:0]])
            begin
                free_map_reg[d_page[PW-1:0]] <= 1'b1;
                free_reg                     <= free_reg + FW'(1);
            end
            else if (cmd.rel_tpage && !free_map_reg[tpage_reg])
            begin
                free_map_reg[tpage_reg] <= 1'b1;
                free_reg                <= free_reg + FW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            action_reg <= req.action;
            root_reg   <= req.table_root[17:PAGE_SHIFT];
            waddr_reg  <= req.word_address;
        end
        if (cmd.save_f)
        begin
            f_reg <= cnt_reg[TW-1:0];
        end
        if (cmd.save_s)
        begin
            s_reg <= cnt_reg[TW-1:0];
        end
        if (cmd.save_last)
        begin
            last_reg <= rdata_reg;
        end
        if (cmd.save_tpage)
        begin
            tpage_reg <= last_reg[PAGE_SHIFT +: PW];
        end
        if (cmd.tpage_from_pg)
        begin
            tpage_reg <= pg_reg;
            s_reg     <= '0;
        end
        if (cmd.ld_in)
        begin
            value_reg <= 32'd0;
        end
        else
        begin
            unique case (cmd.val_op)
                VAL_RDATA:  value_reg <= waddr_ok ? rdata_reg : 32'd0;
                VAL_PGADDR: value_reg <= 32'(pg_reg) << PAGE_SHIFT;
                VAL_DPAGE:  value_reg <= 32'(d_page);
                default:    value_reg <= value_reg;
            endcase
        end
    end

    always_comb
    begin
        sts.action        = action_reg;
        sts.clr_last      = cnt_reg == AW'(MEM_WORDS - 1);
        sts.cnt_full      = cnt_reg == AW'(TABLE_ENTRIES);
        sts.cnt_off_last  = cnt_reg[OFF_W-1:0] == '1;
        sts.rdata_present = rdata_reg[0];
        sts.root_ok       = 32'(root_reg) < 32'(NUM_PAGES);
        sts.tpage_ok      = 32'(last_reg[31:PAGE_SHIFT]) < 32'(NUM_PAGES);
        sts.free_zero     = free_reg == '0;
        sts.free_lt2      = free_reg < FW'(2);
        sts.pg_free       = free_map_reg[pg_reg];
        sts.f_zero        = f_reg == '0;
        sts.f_full        = f_reg == TW'(TABLE_ENTRIES);
        sts.s_zero        = s_reg == '0;
        sts.s_one         = s_reg == TW'(1);
        sts.s_full        = s_reg == TW'(TABLE_ENTRIES);
    end

    assign rsp.value      = value_reg;
    assign rsp.error      = err_reg;
    assign rsp.free_count = 7'(free_reg);

`ifndef SYNTHESIS
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(free_map_reg) == int'(free_reg))
        else $error("free count disagrees with bitmap");
    a_take_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> free_reg == $past(free_reg) - FW'(1))
        else $error("page take did not decrement free count");
    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> value_reg == 32'd0)
        else $error("error result carries nonzero value");
`endif

endmodule

>>> hw/rtl/tlpt_ctrl.sv
module tlpt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    input  tlpt_pkg::sts_t sts,
    output tlpt_pkg::cmd_t cmd
);
    import tlpt_pkg::*;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DISP   = 5'd2;
    localparam logic [4:0] S_RD     = 5'd3;
    localparam logic [4:0] S_RDV    = 5'd4;
    localparam logic [4:0] S_FRD    = 5'd5;
    localparam logic [4:0] S_FCK    = 5'd6;
    localparam logic [4:0] S_POSTF  = 5'd7;
    localparam logic [4:0] S_SRD    = 5'd8;
    localparam logic [4:0] S_SCK    = 5'd9;
    localparam logic [4:0] S_DECIDE = 5'd10;
    localparam logic [4:0] S_FIND1  = 5'd11;
    localparam logic [4:0] S_ZERO   = 5'd12;
    localparam logic [4:0] S_ROOTW  = 5'd13;
    localparam logic [4:0] S_FIND2  = 5'd14;
    localparam logic [4:0] S_DATAW  = 5'd15;
    localparam logic [4:0] S_SHR1   = 5'd16;
    localparam logic [4:0] S_SHR2   = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       need_table;

    assign need_table = sts.f_zero || sts.s_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_CNT;
                cmd.cnt_op   = CNT_INC;
                if (sts.clr_last)
                begin
                    cmd.cnt_op = CNT_CLR;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.ld_in  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.action)
                    ACT_READ:
                    begin
                        state_next = S_RD;
                    end
                    ACT_ALLOC:
                    begin
                        if (sts.free_zero)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.pg_op  = CNT_CLR;
                            state_next = S_FIND1;
                        end
                    end
                    default:
                    begin
                        if (!sts.root_ok)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_CLR;
                            state_next = S_FRD;
                        end
                    end
                endcase
            end
            S_RD:
            begin
                cmd.addr_sel = ADDR_WADDR;
                state_next   = S_RDV;
            end
            S_RDV:
            begin
                cmd.val_op = VAL_RDATA;
                state_next = S_DONE;
            end
            S_FRD:
            begin
                cmd.psel = PSEL_ROOT;
                if (sts.cnt_full)
                begin
                    cmd.save_f = 1'b1;
                    state_next = S_POSTF;
                end
                else
                begin
                    state_next = S_FCK;
                end
            end
            S_FCK:
            begin
                if (sts.rdata_present)
                begin
                    cmd.save_last = 1'b1;
                    cmd.cnt_op    = CNT_INC;
                    state_next    = S_FRD;
                end
                else
                begin
                    cmd.save_f = 1'b1;
                    state_next = S_POSTF;
                end
            end
            S_POSTF:
            begin
                priority if (sts.f_zero)
                begin
                    state_next = S_DECIDE;
                end
                else if (!sts.tpage_ok)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.save_tpage = 1'b1;
                    cmd.cnt_op     = CNT_CLR;
                    state_next     = S_SRD;
                end
            end
            S_SRD:
            begin
                cmd.psel = PSEL_TBL;
                if (sts.cnt_full)
                begin
                    cmd.save_s = 1'b1;
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCK;
                end
            end
            S_SCK:
            begin
                if (sts.rdata_present)
                begin
                    cmd.save_last = 1'b1;
                    cmd.cnt_op    = CNT_INC;
                    state_next    = S_SRD;
                end
                else
                begin
                    cmd.save_s = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.action == ACT_GROW)
                begin
                    priority if (need_table && sts.f_full)
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = S_DONE;
                    end
                    else if (need_table ? sts.free_lt2 : sts.free_zero)
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.pg_op  = CNT_CLR;
                        state_next = need_table ? S_FIND1 : S_FIND2;
                    end
                end
                else
                begin
                    if (sts.f_zero || sts.s_zero)
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHR1;
                    end
                end
            end
            S_FIND1:
            begin
                if (sts.pg_free)
                begin
                    cmd.take   = 1'b1;
                    cmd.cnt_op = CNT_CLR;
                    state_next = S_ZERO;
                end
                else
                begin
                    cmd.pg_op = CNT_INC;
                end
            end
            S_ZERO:
            begin
                cmd.mem_we = 1'b1;
                cmd.psel   = PSEL_PG;
                cmd.cnt_op = CNT_INC;
                if (sts.cnt_off_last)
                begin
                    if (sts.action == ACT_ALLOC)
                    begin
                        cmd.val_op = VAL_PGADDR;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ROOTW;
                    end
                end
            end
            S_ROOTW:
            begin
                cmd.mem_we        = 1'b1;
                cmd.psel          = PSEL_ROOT;
                cmd.off_sel       = OFF_F;
                cmd.wd_entry      = 1'b1;
                cmd.tpage_from_pg = 1'b1;
                cmd.pg_op         = CNT_CLR;
                state_next        = S_FIND2;
            end
            S_FIND2:
            begin
                if (sts.pg_free)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DATAW;
                end
                else
                begin
                    cmd.pg_op = CNT_INC;
                end
            end
            S_DATAW:
            begin
                cmd.mem_we   = 1'b1;
                cmd.psel     = PSEL_TBL;
                cmd.off_sel  = OFF_S;
                cmd.wd_entry = 1'b1;
                cmd.val_op   = VAL_PGADDR;
                state_next   = S_DONE;
            end
            S_SHR1:
            begin
                cmd.rel_data = 1'b1;
                cmd.mem_we   = 1'b1;
                cmd.psel     = PSEL_TBL;
                cmd.off_sel  = OFF_SM1;
                cmd.val_op   = VAL_DPAGE;
                state_next   = sts.s_one ? S_SHR2 : S_DONE;
            end
            S_SHR2:
            begin
                cmd.rel_tpage = 1'b1;
                cmd.mem_we    = 1'b1;
                cmd.psel      = PSEL_ROOT;
                cmd.off_sel   = OFF_FM1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

`ifndef SYNTHESIS
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result beat");
    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not start work");
    a_take_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> sts.pg_free)
        else $error("taking a page that is not free");
`endif

endmodule

>>> hw/rtl/two_level_page_table_grow_shrink.sv
// channel   signals            direction  beat
// request   start, request     in         start && !busy at rising edge
// result    done, result       out        done high for one cycle
//
// alloc_root takes a page search plus a zeroing sweep of the new page
// grow/shrink scan the root and the last second-level table entry by entry,
// grow adds up to two page searches and a zeroing sweep of a new table page
// read_word is one memory read; all cost comes from the single memory port
// after reset the memory is swept to zero with busy high
// the receiver cannot stall: each result is shown for exactly one cycle
module two_level_page_table_grow_shrink #(
    parameter int NUM_PAGES = tlpt_pkg::DEF_NUM_PAGES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  tlpt_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output tlpt_pkg::rsp_t result
);
    import tlpt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: scans, page search, zeroing sweep
    tlpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    // page memory, free bitmap and working registers
    tlpt_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (request),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (result)
    );

endmodule
